/* rtl/itp_pkg.sv */
// Shared types, codes and helpers for the infix-to-postfix converter.
package itp_pkg;

  localparam int unsigned StackDepth = 16;
  localparam int unsigned SpW = $clog2(StackDepth);
  localparam int unsigned CntW = $clog2(StackDepth + 1);

  // token kinds
  localparam logic [2:0] KIND_NUM  = 3'd0;
  localparam logic [2:0] KIND_NEND = 3'd1;
  localparam logic [2:0] KIND_OP   = 3'd2;
  localparam logic [2:0] KIND_DONE = 3'd3;
  localparam logic [2:0] KIND_ERR  = 3'd4;

  // error codes
  localparam logic [7:0] ERR_CHAR  = 8'd0;
  localparam logic [7:0] ERR_WORD  = 8'd1;
  localparam logic [7:0] ERR_CLOSE = 8'd2;
  localparam logic [7:0] ERR_OPEN  = 8'd3;
  localparam logic [7:0] ERR_OVF   = 8'd4;

  // operator ids
  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_MUL  = 4'd2;
  localparam logic [3:0] OP_DIV  = 4'd3;
  localparam logic [3:0] OP_MOD  = 4'd4;
  localparam logic [3:0] OP_POW  = 4'd5;
  localparam logic [3:0] OP_LOG  = 4'd6;
  localparam logic [3:0] OP_SQRT = 4'd7;
  localparam logic [3:0] OP_SEN  = 4'd8;
  localparam logic [3:0] OP_COS  = 4'd9;
  localparam logic [3:0] OP_TAN  = 4'd10;
  localparam logic [3:0] OP_RAIZ = 4'd11;
  localparam logic [3:0] OP_OPEN = 4'd12;

  // scan modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_NUM  = 2'd1;
  localparam logic [1:0] MODE_WORD = 2'd2;
  localparam logic [1:0] MODE_SIGN = 2'd3;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic       eor;
  } token_t;

  function automatic logic [1:0] prec_of(input logic [3:0] id);
    if (id <= OP_SUB) return 2'd1;
    if (id <= OP_MOD) return 2'd2;
    if (id == OP_POW) return 2'd3;
    return 2'd0;
  endfunction

  // functions have top precedence; prec 4 folded as a flag
  function automatic logic is_func(input logic [3:0] id);
    return (id >= OP_LOG) && (id <= OP_RAIZ);
  endfunction

  // word lookup: returns {hit, id}
  function automatic logic [4:0] word_lookup(input logic [31:0] w, input logic [2:0] n);
    logic [4:0] r;
    r = 5'd0;
    if (n == 3'd3 && w == {8'd0, "log"})  r = {1'b1, OP_LOG};
    if (n == 3'd4 && w == "sqrt")         r = {1'b1, OP_SQRT};
    if (n == 3'd4 && w == "raiz")         r = {1'b1, OP_RAIZ};
    if (n == 3'd3 && w == {8'd0, "sen"})  r = {1'b1, OP_SEN};
    if (n == 3'd3 && w == {8'd0, "cos"})  r = {1'b1, OP_COS};
    if (n == 3'd3 && w == {8'd0, "tan"})  r = {1'b1, OP_TAN};
    if (n == 3'd2 && w == {16'd0, "tg"})  r = {1'b1, OP_TAN};
    return r;
  endfunction

endpackage

/* rtl/itp_ram.sv */
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module itp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* rtl/infix_to_postfix_converter.sv */
// Top level: shunting-yard infix-to-postfix converter with sequencer and stack RAM.
//
// One character is taken per item, and stall_o stays high until that item is finished. A
// plain character passes through the steps accept, decode, act and finish. A further
// character of a number skips the act step. Each stack pop takes a read step and a compare
// step because the operator stack is a RAM with a registered read: the sequencer reads the
// top, then compares and emits. A binary operator therefore runs one read and compare per
// pop, plus a last compare and the push. A closing parenthesis runs one per pop, one for
// its opener and one for the check of a waiting function. The last character of an
// expression then runs the flush: it closes an open number or word, pops each remaining
// stack entry and emits the done token. Output tokens pass through a single register;
// the states that emit a token wait while that register is full and stalled.
module infix_to_postfix_converter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       stall_o,
  input  logic [7:0] ch_i,
  input  logic       last_char_i,
  output logic       valid_o,
  input  logic       stall_i,
  output logic [2:0] token_kind_o,
  output logic [7:0] token_value_o,
  output logic       end_of_run_o
);
  import itp_pkg::*;

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEC    = 4'd1;  // act on character in current mode
  localparam logic [3:0] S_MAIN   = 4'd2;  // character after mode handling
  localparam logic [3:0] S_RDOP   = 4'd3;  // operator pop loop: read wait
  localparam logic [3:0] S_CKOP   = 4'd4;  // operator pop loop: compare top
  localparam logic [3:0] S_RDCL   = 4'd5;  // close paren loop: read wait
  localparam logic [3:0] S_CKCL   = 4'd6;
  localparam logic [3:0] S_RDFN   = 4'd7;  // function after opener
  localparam logic [3:0] S_CKFN   = 4'd8;
  localparam logic [3:0] S_FLUSH  = 4'd9;  // flush: mode end
  localparam logic [3:0] S_RDFL   = 4'd10;
  localparam logic [3:0] S_CKFL   = 4'd11;
  localparam logic [3:0] S_FIN    = 4'd12; // finish item, rearm if last

  logic [3:0]       state_q, state_d;
  logic [7:0]       ch_q, ch_d;
  logic             last_q, last_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [1:0]       mode_q, mode_d;
  logic [31:0]      word_q, word_d;
  logic [2:0]       wlen_q, wlen_d;
  logic             expect_q, expect_d;
  logic             err_q, err_d;
  logic [3:0]       opid_q, opid_d;

  logic             ovalid_q, ovalid_d;
  token_t           otok_q, otok_d;

  // stack RAM
  logic             we;
  logic [SpW-1:0]   waddr, raddr;
  logic [3:0]       wdata, top;

  itp_ram #(.Width(4), .Depth(StackDepth)) u_stack (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(top)
  );

  logic [CntW-1:0] cnt_m1;
  assign cnt_m1 = cnt_q - CntW'(1);
  assign raddr  = cnt_m1[SpW-1:0];
  assign waddr  = cnt_q[SpW-1:0];

  logic out_free;
  assign out_free = !ovalid_q || !stall_i;

  // character classes
  logic is_digit, is_num, is_letter, is_ws;
  logic [7:0] nc;
  assign is_digit  = ch_q >= "0" && ch_q <= "9";
  assign is_num    = is_digit || ch_q == "." || ch_q == ",";
  assign is_letter = (ch_q >= "a" && ch_q <= "z") || (ch_q >= "A" && ch_q <= "Z");
  assign is_ws     = ch_q == " " || (ch_q >= 8'd9 && ch_q <= 8'd13);
  assign nc        = (ch_q == ",") ? 8'(".") : ch_q;

  logic [4:0] wl;
  assign wl = word_lookup(word_q, wlen_q);

  logic       pop_ok;
  logic [1:0] p_new, p_top;
  assign p_new  = prec_of(opid_q);
  assign p_top  = prec_of(top);
  assign pop_ok = top != OP_OPEN &&
                  (is_func(top) || p_top > p_new || (p_top == p_new && opid_q != OP_POW));

  assign stall_o = state_q != S_IDLE;

  always_comb begin
    state_d  = state_q;
    ch_d     = ch_q;
    last_d   = last_q;
    cnt_d    = cnt_q;
    mode_d   = mode_q;
    word_d   = word_q;
    wlen_d   = wlen_q;
    expect_d = expect_q;
    err_d    = err_q;
    opid_d   = opid_q;
    we       = 1'b0;
    wdata    = opid_q;
    ovalid_d = ovalid_q && stall_i;
    otok_d   = otok_q;

    unique case (state_q)
      S_IDLE: begin
        if (valid_i) begin
          ch_d   = ch_i;
          last_d = last_char_i;
          state_d = err_q ? S_FIN : S_DEC;
        end
      end
      S_DEC: begin
        if (out_free) begin
          state_d = S_MAIN;
          unique case (mode_q)
            MODE_NUM: begin
              if (is_num) begin
                ovalid_d = 1'b1; otok_d = '{KIND_NUM, nc, 1'b0};
                state_d = S_FIN;
              end else begin
                ovalid_d = 1'b1; otok_d = '{KIND_NEND, 8'd0, 1'b0};
                mode_d = MODE_IDLE; expect_d = 1'b0;
              end
            end
            MODE_SIGN: begin
              ovalid_d = 1'b1;
              state_d = S_FIN;
              if (is_num) begin
                otok_d = '{KIND_NUM, nc, 1'b0}; mode_d = MODE_NUM;
              end else begin
                otok_d = '{KIND_ERR, ERR_CHAR, 1'b1}; err_d = 1'b1;
              end
            end
            MODE_WORD: begin
              if (is_letter) begin
                state_d = S_FIN;
                if (wlen_q >= 3'd4) begin
                  ovalid_d = 1'b1; otok_d = '{KIND_ERR, ERR_WORD, 1'b1}; err_d = 1'b1;
                end else begin
                  word_d = {word_q[23:0], ch_q}; wlen_d = wlen_q + 3'd1;
                end
              end else if (!wl[4]) begin
                ovalid_d = 1'b1; otok_d = '{KIND_ERR, ERR_WORD, 1'b1}; err_d = 1'b1;
                state_d = S_FIN;
              end else if (cnt_q >= CntW'(StackDepth)) begin
                ovalid_d = 1'b1; otok_d = '{KIND_ERR, ERR_OVF, 1'b1}; err_d = 1'b1;
                state_d = S_FIN;
              end else begin
                we = 1'b1; wdata = wl[3:0]; cnt_d = cnt_q + CntW'(1);
                mode_d = MODE_IDLE; word_d = '0; wlen_d = '0; expect_d = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_MAIN: begin
        state_d = S_FIN;
        if (is_ws) begin
        end else if (is_num) begin
          if (out_free) begin
            ovalid_d = 1'b1; otok_d = '{KIND_NUM, nc, 1'b0}; mode_d = MODE_NUM;
          end else state_d = S_MAIN;
        end else if (is_letter) begin
          mode_d = MODE_WORD; word_d = {24'd0, ch_q}; wlen_d = 3'd1;
        end else if (ch_q == "(") begin
          expect_d = 1'b1; opid_d = OP_OPEN;
          if (cnt_q >= CntW'(StackDepth)) begin
            if (out_free) begin
              ovalid_d = 1'b1; otok_d = '{KIND_ERR, ERR_OVF, 1'b1}; err_d = 1'b1;
            end else state_d = S_MAIN;
          end else begin
            we = 1'b1; wdata = OP_OPEN; cnt_d = cnt_q + CntW'(1);
          end
        end else if (ch_q == ")") begin
          state_d = S_RDCL;
        end else begin
          case (ch_q)
            "+": opid_d = OP_ADD;
            "-": opid_d = OP_SUB;
            "*": opid_d = OP_MUL;
            "/": opid_d = OP_DIV;
            "%": opid_d = OP_MOD;
            "^": opid_d = OP_POW;
            default: opid_d = OP_OPEN;
          endcase
          if (out_free) begin
            if (opid_d == OP_OPEN) begin
              ovalid_d = 1'b1; otok_d = '{KIND_ERR, ERR_CHAR, 1'b1}; err_d = 1'b1;
            end else if (opid_d == OP_SUB && expect_q) begin
              ovalid_d = 1'b1; otok_d = '{KIND_NUM, 8'("-"), 1'b0}; mode_d = MODE_SIGN;
            end else begin
              state_d = S_RDOP;
            end
          end else state_d = S_MAIN;
        end
      end
      S_RDOP: state_d = S_CKOP;
      S_CKOP: begin
        if (out_free) begin
          if (cnt_q != '0 && pop_ok) begin
            ovalid_d = 1'b1; otok_d = '{KIND_OP, {4'd0, top}, 1'b0};
            cnt_d = cnt_m1; state_d = S_RDOP;
          end else begin
            expect_d = 1'b1; state_d = S_FIN;
            if (cnt_q >= CntW'(StackDepth)) begin
              ovalid_d = 1'b1; otok_d = '{KIND_ERR, ERR_OVF, 1'b1}; err_d = 1'b1;
            end else begin
              we = 1'b1; cnt_d = cnt_q + CntW'(1);
            end
          end
        end
      end
      S_RDCL: state_d = S_CKCL;
      S_CKCL: begin
        if (out_free) begin
          if (cnt_q == '0) begin
            ovalid_d = 1'b1; otok_d = '{KIND_ERR, ERR_CLOSE, 1'b1}; err_d = 1'b1;
            state_d = S_FIN;
          end else if (top != OP_OPEN) begin
            ovalid_d = 1'b1; otok_d = '{KIND_OP, {4'd0, top}, 1'b0};
            cnt_d = cnt_m1; state_d = S_RDCL;
          end else begin
            cnt_d = cnt_m1; state_d = S_RDFN;
          end
        end
      end
      S_RDFN: state_d = S_CKFN;
      S_CKFN: begin
        if (out_free) begin
          expect_d = 1'b0; state_d = S_FIN;
          if (cnt_q != '0 && is_func(top)) begin
            ovalid_d = 1'b1; otok_d = '{KIND_OP, {4'd0, top}, 1'b0}; cnt_d = cnt_m1;
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          state_d = S_RDFL;
          unique case (mode_q)
            MODE_NUM: begin
              ovalid_d = 1'b1; otok_d = '{KIND_NEND, 8'd0, 1'b0};
              mode_d = MODE_IDLE; expect_d = 1'b0;
            end
            MODE_SIGN: begin
              ovalid_d = 1'b1; otok_d = '{KIND_ERR, ERR_CHAR, 1'b1}; err_d = 1'b1;
              state_d = S_FIN;
            end
            MODE_WORD: begin
              if (!wl[4]) begin
                ovalid_d = 1'b1; otok_d = '{KIND_ERR, ERR_WORD, 1'b1}; err_d = 1'b1;
                state_d = S_FIN;
              end else if (cnt_q >= CntW'(StackDepth)) begin
                ovalid_d = 1'b1; otok_d = '{KIND_ERR, ERR_OVF, 1'b1}; err_d = 1'b1;
                state_d = S_FIN;
              end else begin
                we = 1'b1; wdata = wl[3:0]; cnt_d = cnt_q + CntW'(1);
                mode_d = MODE_IDLE;
              end
            end
            default: ;
          endcase
        end
      end
      S_RDFL: state_d = S_CKFL;
      S_CKFL: begin
        if (out_free) begin
          if (cnt_q == '0) begin
            ovalid_d = 1'b1; otok_d = '{KIND_DONE, 8'd0, 1'b1}; state_d = S_FIN;
          end else if (top == OP_OPEN) begin
            ovalid_d = 1'b1; otok_d = '{KIND_ERR, ERR_OPEN, 1'b1}; err_d = 1'b1;
            state_d = S_FIN;
          end else begin
            ovalid_d = 1'b1; otok_d = '{KIND_OP, {4'd0, top}, 1'b0};
            cnt_d = cnt_m1; state_d = S_RDFL;
          end
        end
      end
      S_FIN: begin
        state_d = S_IDLE;
        if (err_q && !last_q) begin
          // error: clear the run, drop characters until the last one
          cnt_d = '0; mode_d = MODE_IDLE; word_d = '0; wlen_d = '0; expect_d = 1'b1;
        end else if (last_q) begin
          cnt_d = '0; mode_d = MODE_IDLE; word_d = '0; wlen_d = '0; expect_d = 1'b1;
          err_d = 1'b0;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // route last characters that did not fail into the flush
  logic [3:0] state_nx;
  always_comb begin
    state_nx = state_d;
    if (state_d == S_FIN && state_q != S_FIN && state_q != S_IDLE && last_q && !err_d)
      state_nx = (state_q == S_FLUSH || state_q == S_CKFL) ? S_FIN : S_FLUSH;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      mode_q   <= MODE_IDLE;
      word_q   <= '0;
      wlen_q   <= '0;
      expect_q <= 1'b1;
      err_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_nx;
      cnt_q    <= cnt_d;
      mode_q   <= mode_d;
      word_q   <= word_d;
      wlen_q   <= wlen_d;
      expect_q <= expect_d;
      err_q    <= err_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    last_q <= last_d;
    opid_q <= opid_d;
    otok_q <= otok_d;
  end

  assign valid_o       = ovalid_q;
  assign token_kind_o  = otok_q.kind;
  assign token_value_o = otok_q.value;
  assign end_of_run_o  = otok_q.eor;

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(StackDepth)) else $error("stack count out of range");
  a_idle_after_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && err_q) |-> cnt_q == '0) else $error("stack not cleared on error");
  a_eor_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (end_of_run_o == (token_kind_o == KIND_DONE || token_kind_o == KIND_ERR)))
    else $error("end of run flag mismatch");
endmodule

/* test/infix_to_postfix_converter_test.sv */
// Self-checking testbench for the infix-to-postfix converter.
module infix_to_postfix_converter_test;
  timeunit 1ns;
  timeprecision 1ps;
  import itp_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       valid_i = 1'b0;
  logic       stall_o;
  logic [7:0] ch_i = 8'd0;
  logic       last_char_i = 1'b0;
  logic       valid_o;
  logic       stall_i = 1'b0;
  logic [2:0] token_kind_o;
  logic [7:0] token_value_o;
  logic       end_of_run_o;

  infix_to_postfix_converter uut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // predictor state
  logic [3:0]  op_stack [StackDepth];
  int unsigned op_count;
  logic [1:0]  scan_mode;
  logic [31:0] word_buf;
  int unsigned word_len;
  bit          want_operand;
  bit          err_held;

  token_t      pending_tokens [$];
  int unsigned mismatches = 0;
  bit          idle_off = 1'b0;
  bit          hold_long = 1'b0;
  int unsigned cycle_count = 0;

  task automatic report(input string what);
    $display("mismatch: %s", what);
    mismatches++;
  endtask

  function automatic void push_token(input logic [2:0] k, input logic [7:0] v, input bit e);
    token_t t;
    t.kind = k;
    t.value = v;
    t.eor = e;
    pending_tokens.push_back(t);
  endfunction

  function automatic void clear_expr();
    op_count = 0;
    scan_mode = MODE_IDLE;
    word_buf = '0;
    word_len = 0;
    want_operand = 1'b1;
  endfunction

  function automatic void raise_error(input logic [7:0] code);
    push_token(KIND_ERR, code, 1'b1);
    clear_expr();
    err_held = 1'b1;
  endfunction

  function automatic bit push_op(input logic [3:0] id);
    if (op_count >= StackDepth) begin
      raise_error(ERR_OVF);
      return 1'b0;
    end
    op_stack[op_count] = id;
    op_count++;
    return 1'b1;
  endfunction

  function automatic int prec(input logic [3:0] id);
    if (id <= OP_SUB) return 1;
    if (id <= OP_MOD) return 2;
    if (id == OP_POW) return 3;
    if (id <= OP_RAIZ) return 4;
    return 0;
  endfunction

  function automatic void end_number();
    push_token(KIND_NEND, 8'd0, 1'b0);
    scan_mode = MODE_IDLE;
    want_operand = 1'b0;
  endfunction

  function automatic bit end_word();
    logic [3:0] id;
    bit hit;
    hit = 1'b1;
    if (word_len == 3 && word_buf == 32'h006c6f67) id = OP_LOG;
    else if (word_len == 4 && word_buf == 32'h73717274) id = OP_SQRT;
    else if (word_len == 4 && word_buf == 32'h7261697a) id = OP_RAIZ;
    else if (word_len == 3 && word_buf == 32'h0073656e) id = OP_SEN;
    else if (word_len == 3 && word_buf == 32'h00636f73) id = OP_COS;
    else if (word_len == 3 && word_buf == 32'h0074616e) id = OP_TAN;
    else if (word_len == 2 && word_buf == 32'h00007467) id = OP_TAN;
    else hit = 1'b0;
    if (!hit) begin
      raise_error(ERR_WORD);
      return 1'b0;
    end
    scan_mode = MODE_IDLE;
    word_buf = '0;
    word_len = 0;
    want_operand = 1'b1;
    return push_op(id);
  endfunction

  function automatic bit take_char(input logic [7:0] c);
    bit dig, num, let_c;
    logic [7:0] nc;
    logic [3:0] id, top;
    int p, tp;
    dig = c >= "0" && c <= "9";
    num = dig || c == "." || c == ",";
    let_c = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    nc = (c == ",") ? 8'h2e : c;
    if (scan_mode == MODE_NUM) begin
      if (num) begin
        push_token(KIND_NUM, nc, 1'b0);
        return 1'b1;
      end
      end_number();
    end else if (scan_mode == MODE_SIGN) begin
      if (num) begin
        push_token(KIND_NUM, nc, 1'b0);
        scan_mode = MODE_NUM;
        return 1'b1;
      end
      raise_error(ERR_CHAR);
      return 1'b0;
    end else if (scan_mode == MODE_WORD) begin
      if (let_c) begin
        if (word_len >= 4) begin
          raise_error(ERR_WORD);
          return 1'b0;
        end
        word_buf = {word_buf[23:0], c};
        word_len++;
        return 1'b1;
      end
      if (!end_word()) return 1'b0;
    end
    if (c == " " || (c >= 8'd9 && c <= 8'd13)) return 1'b1;
    if (num) begin
      push_token(KIND_NUM, nc, 1'b0);
      scan_mode = MODE_NUM;
      return 1'b1;
    end
    if (let_c) begin
      scan_mode = MODE_WORD;
      word_buf = {24'd0, c};
      word_len = 1;
      return 1'b1;
    end
    if (c == "(") begin
      want_operand = 1'b1;
      return push_op(OP_OPEN);
    end
    if (c == ")") begin
      while (op_count > 0 && op_stack[op_count-1] != OP_OPEN) begin
        op_count--;
        push_token(KIND_OP, {4'd0, op_stack[op_count]}, 1'b0);
      end
      if (op_count == 0) begin
        raise_error(ERR_CLOSE);
        return 1'b0;
      end
      op_count--;
      if (op_count > 0) begin
        id = op_stack[op_count-1];
        if (id >= OP_LOG && id <= OP_RAIZ) begin
          op_count--;
          push_token(KIND_OP, {4'd0, id}, 1'b0);
        end
      end
      want_operand = 1'b0;
      return 1'b1;
    end
    case (c)
      "+": id = OP_ADD;
      "-": id = OP_SUB;
      "*": id = OP_MUL;
      "/": id = OP_DIV;
      "%": id = OP_MOD;
      "^": id = OP_POW;
      default: begin
        raise_error(ERR_CHAR);
        return 1'b0;
      end
    endcase
    if (id == OP_SUB && want_operand) begin
      push_token(KIND_NUM, "-", 1'b0);
      scan_mode = MODE_SIGN;
      return 1'b1;
    end
    p = prec(id);
    while (op_count > 0) begin
      top = op_stack[op_count-1];
      tp = prec(top);
      if (top == OP_OPEN || !(tp > p || (tp == p && id != OP_POW))) break;
      op_count--;
      push_token(KIND_OP, {4'd0, top}, 1'b0);
    end
    want_operand = 1'b1;
    return push_op(id);
  endfunction

  function automatic void flush_expr();
    if (scan_mode == MODE_NUM) end_number();
    else if (scan_mode == MODE_SIGN) begin
      raise_error(ERR_CHAR);
      return;
    end else if (scan_mode == MODE_WORD) begin
      if (!end_word()) return;
    end
    while (op_count > 0) begin
      op_count--;
      if (op_stack[op_count] == OP_OPEN) begin
        raise_error(ERR_OPEN);
        return;
      end
      push_token(KIND_OP, {4'd0, op_stack[op_count]}, 1'b0);
    end
    push_token(KIND_DONE, 8'd0, 1'b1);
    clear_expr();
  endfunction

  function automatic void predict(input logic [7:0] c, input bit last);
    if (err_held) begin
      if (last) begin
        clear_expr();
        err_held = 1'b0;
      end
      return;
    end
    if (take_char(c) && last) flush_expr();
    if (last) begin
      clear_expr();
      err_held = 1'b0;
    end
  endfunction

  // offer one item, with optional leading gap, and wait until it is taken;
  // valid stays high after acceptance unless a gap follows or the run ends
  task automatic send_char(input logic [7:0] c, input bit last);
    int gap;
    if (!idle_off && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    ch_i <= c;
    last_char_i <= last;
    predict(c, last);
    do @(posedge clk_i); while (stall_o);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // result checker
  always @(posedge clk_i) begin
    token_t want;
    if (valid_o && !stall_i) begin
      if (pending_tokens.size() == 0) report("token with nothing expected");
      else begin
        want = pending_tokens.pop_front();
        if (token_kind_o !== want.kind)
          report($sformatf("kind %0d want %0d", token_kind_o, want.kind));
        if (token_value_o !== want.value)
          report($sformatf("value %0d want %0d", token_value_o, want.value));
        if (end_of_run_o !== want.eor)
          report($sformatf("end_of_run %0b want %0b", end_of_run_o, want.eor));
      end
    end
  end

  // receiver stall: random bursts, or one long hold-off
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (hold_long) begin
        stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        stall_i <= 1'b0;
        hold_long = 1'b0;
      end else if (!idle_off && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 5);
        stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        stall_i <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic test_directed();
    send_text("3+4*2");
    send_text("(1-2)^2^3");
    send_text("-5.5,1%7/2");
    send_text("sqrt(9)+log(2)*raiz 4");
    send_text("sen(1)-cos(2)+tan(3)/tg(4)");
    send_text("sen2\t+ 1");
    send_text("-x");
    send_text("logs(1)");
    send_text("abcde");
    send_text("1)");
    send_text("(1+2");
    send_text("1#2");
    send_text("");
    send_char(8'h00, 1'b0);
    send_char(8'hff, 1'b1);
    send_char(" ", 1'b1);
    send_text("..,");
    send_text("((((((((((((((((((1");
  endtask

  function automatic string rand_expr(input int depth);
    string s;
    int k;
    string fn [7] = '{"log", "sqrt", "raiz", "sen", "cos", "tan", "tg"};
    string op [6] = '{"+", "-", "*", "/", "%", "^"};
    k = $urandom_range(0, 5);
    if (depth > 2 || k < 3) begin
      s = $sformatf("%0d", $urandom_range(0, 999));
      if ($urandom_range(0, 3) == 0) s = {s, ($urandom_range(0, 1) ? "." : ","), "5"};
      if ($urandom_range(0, 4) == 0) s = {"-", s};
    end else if (k == 3) s = {fn[$urandom_range(0, 6)], "(", rand_expr(depth + 1), ")"};
    else s = {"(", rand_expr(depth + 1), ")"};
    if ($urandom_range(0, 2) != 0)
      s = {s, ($urandom_range(0, 1) ? " " : ""), op[$urandom_range(0, 5)], rand_expr(depth + 1)};
    return s;
  endfunction

  task automatic test_random();
    string s;
    int sent;
    sent = 0;
    while (sent < 300) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise: arbitrary bytes
        for (int i = 0; i < 4; i++) begin
          send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
          sent++;
        end
        send_char(" ", 1'b1);
        sent++;
      end else begin
        s = rand_expr(0);
        if (s.len() > 60) s = "1+2";
        if ($urandom_range(0, 7) == 0) s[$urandom_range(0, s.len() - 1)] = ")";
        send_text(s);
        sent += s.len();
      end
      if (sent > 220) idle_off = 1'b1;
    end
  endtask

  task automatic test_backpressure();
    hold_long = 1'b1;
    send_text("1+2*3-4/5+6*7-8+9*1-2+3*4-5+6");
  endtask

  initial begin
    int waited;
    clear_expr();
    err_held = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random();
    valid_i <= 1'b0;
    waited = 0;
    while (pending_tokens.size() != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && pending_tokens.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* files.f */
rtl/itp_pkg.sv
rtl/itp_ram.sv
rtl/infix_to_postfix_converter.sv
test/infix_to_postfix_converter_test.sv
